// File: src/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types and codes shared by the distance-vector route table core.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam logic [2:0] OP_PING     = 3'd0;
    localparam logic [2:0] OP_NEW_HERE = 3'd1;
    localparam logic [2:0] OP_ENTRY    = 3'd2;
    localparam logic [2:0] OP_DELETE   = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [2:0] ACT_BROADCAST = 3'd0;
    localparam logic [2:0] ACT_DELETE    = 3'd1;
    localparam logic [2:0] ACT_ANNOUNCE  = 3'd2;
    localparam logic [2:0] ACT_ENTRY     = 3'd3;
    localparam logic [2:0] ACT_FULL      = 3'd4;

    localparam logic [2:0] RESULT_SLOTS = 3'd4;

    localparam logic [7:0] MY_ID_RESET   = 8'd1;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam logic [7:0] HOPS_MAX      = 8'd255;

    localparam logic [0:0] REG_MY_ID   = 1'b0;
    localparam logic [0:0] REG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] port;
        logic [7:0] sender_id;
        logic [7:0] node_id;
        logic [7:0] hops;
        logic       last_entry;
        logic [3:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] node_id_out;
        logic [7:0] next_hop_out;
        logic [7:0] hops_out;
        logic       entry_valid;
        logic [4:0] table_count;
        logic       last_result;
    } out_item_t;

    // one buffered result before count and last flag are attached
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] node_id;
        logic [7:0] next_hop;
        logic [7:0] hops;
        logic       valid;
    } result_t;

    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] next_hop;
        logic [7:0] hop_count;
    } route_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FIND,
        ST_POST,
        ST_SHIFT,
        ST_TICK,
        ST_READ,
        ST_LAST,
        ST_OUT
    } state_t;

endpackage

// File: src/dvrt_route_ram.sv
// ----------------------------------------------------------------------------
// dvrt_route_ram
// Route table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dvrt_route_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  dvrt_pkg::route_entry_t wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output dvrt_pkg::route_entry_t rd_data
);

    dvrt_pkg::route_entry_t mem [DEPTH];
    dvrt_pkg::route_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/distance_vector_route_table_core.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_core
// Ordered route table with per-port neighbor ages; message events in,
// action items out.
// ----------------------------------------------------------------------------
//  channel   ports              payload      accepted when
//  input     s_valid/s_ready    s_data       s_valid && s_ready
//  result    m_valid/m_ready    m_data       m_valid && m_ready
//  config    APB psel..pready   pwdata[7:0]  psel && penable && pwrite
//
//  One item at a time. A route search reads the table RAM one entry per
//  cycle; a shifting delete moves one entry per cycle; a tick walks one
//  port per cycle plus a search/shift per drop. Results are then
//  delivered one per cycle while m_ready is high.
//  Reset clears counts and neighbors; table RAM contents are not cleared.
//  Results wait in a 4-entry buffer; m_ready low stalls delivery, and s_ready stays low until the last result is taken.
// ----------------------------------------------------------------------------
module distance_vector_route_table_core #(
    parameter int ROUTE_ENTRIES = 16,
    parameter int PORT_COUNT    = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dvrt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dvrt_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CW  = $clog2(ROUTE_ENTRIES + 1);
    localparam int PIW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int TW  = $clog2(PORT_COUNT + 1);
    localparam logic [CW-1:0] RE_C = CW'(ROUTE_ENTRIES);
    localparam logic [TW-1:0] PC_C = TW'(PORT_COUNT);

    dvrt_pkg::state_t   state_reg, state_next;
    dvrt_pkg::in_item_t item_reg, item_next;
    logic [7:0]    my_id_reg, timeout_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          changed_reg, changed_next;
    logic [7:0]    nb_node_reg [PORT_COUNT];
    logic [7:0]    nb_node_next [PORT_COUNT];
    logic [7:0]    nb_age_reg [PORT_COUNT];
    logic [7:0]    nb_age_next [PORT_COUNT];
    logic [7:0]    key_reg, key_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] chk_reg, chk_next;
    logic          found_reg, found_next;
    logic [CW-1:0] shift_reg, shift_next;
    logic [TW-1:0] tick_reg, tick_next;
    dvrt_pkg::result_t res_reg [4];
    logic [2:0]    res_n_reg, res_n_next;
    logic [1:0]    out_idx_reg, out_idx_next;

    logic                   emit_en;
    dvrt_pkg::result_t      emit_data;
    logic                   rd_en, wr_en;
    logic [AW-1:0]          rd_addr, wr_addr;
    dvrt_pkg::route_entry_t rd_data, wr_data;

    // shared conditions
    logic [PIW-1:0] pidx, tidx;
    logic           port_ok, ping_learn, match, more, shift_more, shift_done;
    logic           rd_ok, rm_ok, room, tick_end, out_last;
    logic [7:0]     via, cost, age_inc;

    assign pidx       = PIW'(item_reg.port);
    assign tidx       = PIW'(tick_reg);
    assign port_ok    = 5'(item_reg.port) < 5'(PORT_COUNT);
    assign ping_learn = port_ok && (nb_node_reg[pidx] != item_reg.sender_id);
    assign match      = pend_reg && (rd_data.dest == key_reg);
    assign more       = issue_reg < count_reg;
    assign shift_more = shift_reg < count_reg;
    assign shift_done = !shift_more && !pend_reg;
    assign rd_ok      = 9'(item_reg.entry_index) < 9'(count_reg);
    assign via        = (item_reg.op == dvrt_pkg::OP_TICK) ? key_reg : item_reg.sender_id;
    assign rm_ok      = found_reg && (rd_data.next_hop == via);
    assign room       = count_reg < RE_C;
    assign cost       = (item_reg.hops == dvrt_pkg::HOPS_MAX) ? dvrt_pkg::HOPS_MAX
                                                              : item_reg.hops + 8'd1;
    assign tick_end   = tick_reg == PC_C;
    assign age_inc    = (nb_age_reg[tidx] == dvrt_pkg::HOPS_MAX) ? dvrt_pkg::HOPS_MAX
                                                                 : nb_age_reg[tidx] + 8'd1;
    assign out_last   = ({1'b0, out_idx_reg} + 3'd1) == res_n_reg;

    dvrt_route_ram #(
        .DEPTH(ROUTE_ENTRIES),
        .AW   (AW)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dvrt_pkg::ST_IDLE: begin
                if (s_valid) state_next = dvrt_pkg::ST_DISPATCH;
            end
            dvrt_pkg::ST_DISPATCH: begin
                case (item_reg.op)
                    dvrt_pkg::OP_PING:
                        state_next = ping_learn ? dvrt_pkg::ST_FIND : dvrt_pkg::ST_OUT;
                    dvrt_pkg::OP_NEW_HERE: state_next = dvrt_pkg::ST_FIND;
                    dvrt_pkg::OP_ENTRY:    state_next = dvrt_pkg::ST_FIND;
                    dvrt_pkg::OP_DELETE:
                        state_next = (item_reg.node_id == my_id_reg) ? dvrt_pkg::ST_OUT
                                                                     : dvrt_pkg::ST_FIND;
                    dvrt_pkg::OP_TICK:     state_next = dvrt_pkg::ST_TICK;
                    dvrt_pkg::OP_READ:
                        state_next = rd_ok ? dvrt_pkg::ST_READ : dvrt_pkg::ST_OUT;
                    default:               state_next = dvrt_pkg::ST_OUT;
                endcase
            end
            dvrt_pkg::ST_FIND: begin
                if (match || !more) state_next = dvrt_pkg::ST_POST;
            end
            dvrt_pkg::ST_POST: begin
                case (item_reg.op)
                    dvrt_pkg::OP_NEW_HERE: state_next = dvrt_pkg::ST_LAST;
                    dvrt_pkg::OP_ENTRY:
                        state_next = item_reg.last_entry ? dvrt_pkg::ST_LAST
                                                         : dvrt_pkg::ST_OUT;
                    dvrt_pkg::OP_DELETE:
                        state_next = rm_ok ? dvrt_pkg::ST_SHIFT : dvrt_pkg::ST_OUT;
                    dvrt_pkg::OP_TICK:
                        state_next = rm_ok ? dvrt_pkg::ST_SHIFT : dvrt_pkg::ST_TICK;
                    default:               state_next = dvrt_pkg::ST_OUT;
                endcase
            end
            dvrt_pkg::ST_SHIFT: begin
                if (shift_done) begin
                    state_next = (item_reg.op == dvrt_pkg::OP_TICK) ? dvrt_pkg::ST_TICK
                                                                    : dvrt_pkg::ST_OUT;
                end
            end
            dvrt_pkg::ST_TICK: begin
                if (tick_end) begin
                    state_next = dvrt_pkg::ST_OUT;
                end else if (nb_node_reg[tidx] != 8'd0 && age_inc > timeout_reg) begin
                    state_next = dvrt_pkg::ST_FIND;
                end
            end
            dvrt_pkg::ST_READ: state_next = dvrt_pkg::ST_OUT;
            dvrt_pkg::ST_LAST: state_next = dvrt_pkg::ST_OUT;
            dvrt_pkg::ST_OUT: begin
                if (res_n_reg == 3'd0 || (m_ready && out_last)) begin
                    state_next = dvrt_pkg::ST_IDLE;
                end
            end
            default: state_next = dvrt_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        item_next    = item_reg;
        count_next   = count_reg;
        changed_next = changed_reg;
        nb_node_next = nb_node_reg;
        nb_age_next  = nb_age_reg;
        key_next     = key_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        chk_next     = chk_reg;
        found_next   = found_reg;
        shift_next   = shift_reg;
        tick_next    = tick_reg;
        out_idx_next = out_idx_reg;
        emit_en      = 1'b0;
        emit_data    = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        s_ready      = state_reg == dvrt_pkg::ST_IDLE;
        m_valid      = (state_reg == dvrt_pkg::ST_OUT) && (res_n_reg != 3'd0);
        issue_next   = (state_reg == dvrt_pkg::ST_FIND) ? issue_reg : '0;

        case (state_reg)
            dvrt_pkg::ST_IDLE: begin
                item_next    = s_data;
                out_idx_next = '0;
            end
            dvrt_pkg::ST_DISPATCH: begin
                case (item_reg.op)
                    dvrt_pkg::OP_PING: begin
                        key_next = item_reg.sender_id;
                        if (port_ok) nb_age_next[pidx] = 8'd0;
                    end
                    dvrt_pkg::OP_NEW_HERE: key_next = item_reg.sender_id;
                    dvrt_pkg::OP_ENTRY:    key_next = item_reg.node_id;
                    dvrt_pkg::OP_DELETE: begin
                        key_next = item_reg.node_id;
                        if (item_reg.node_id == my_id_reg) begin
                            emit_en          = 1'b1;
                            emit_data.action = dvrt_pkg::ACT_ANNOUNCE;
                        end
                    end
                    dvrt_pkg::OP_TICK: tick_next = '0;
                    dvrt_pkg::OP_READ: begin
                        if (rd_ok) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(item_reg.entry_index);
                        end else begin
                            emit_en          = 1'b1;
                            emit_data.action = dvrt_pkg::ACT_ENTRY;
                        end
                    end
                    default: ;
                endcase
            end
            dvrt_pkg::ST_FIND: begin
                if (match) begin
                    found_next = 1'b1;
                end else if (more) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(issue_reg);
                    chk_next   = AW'(issue_reg);
                    pend_next  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end else begin
                    found_next = 1'b0;
                end
            end
            dvrt_pkg::ST_POST: begin
                case (item_reg.op)
                    dvrt_pkg::OP_PING, dvrt_pkg::OP_NEW_HERE: begin
                        wr_data = '{dest: key_reg, next_hop: key_reg, hop_count: 8'd1};
                        if (found_reg) begin
                            wr_en   = 1'b1;
                            wr_addr = chk_reg;
                        end else if (room) begin
                            wr_en      = 1'b1;
                            wr_addr    = AW'(count_reg);
                            count_next = count_reg + 1'b1;
                        end else begin
                            emit_en           = 1'b1;
                            emit_data.action  = dvrt_pkg::ACT_FULL;
                            emit_data.node_id = key_reg;
                        end
                        if (port_ok) begin
                            nb_node_next[pidx] = item_reg.sender_id;
                            nb_age_next[pidx]  = 8'd0;
                        end
                    end
                    dvrt_pkg::OP_ENTRY: begin
                        wr_data = '{dest: key_reg, next_hop: item_reg.sender_id,
                                    hop_count: cost};
                        if (found_reg) begin
                            if (rd_data.hop_count > cost) begin
                                wr_en        = 1'b1;
                                wr_addr      = chk_reg;
                                changed_next = 1'b1;
                            end
                        end else if (key_reg != my_id_reg) begin
                            if (room) begin
                                wr_en        = 1'b1;
                                wr_addr      = AW'(count_reg);
                                count_next   = count_reg + 1'b1;
                                changed_next = 1'b1;
                            end else begin
                                emit_en           = 1'b1;
                                emit_data.action  = dvrt_pkg::ACT_FULL;
                                emit_data.node_id = key_reg;
                            end
                        end
                    end
                    dvrt_pkg::OP_DELETE: begin
                        if (!rm_ok) begin
                            emit_en          = 1'b1;
                            emit_data.action = dvrt_pkg::ACT_BROADCAST;
                        end
                    end
                    default: ;
                endcase
                shift_next = CW'(chk_reg) + 1'b1;
            end
            dvrt_pkg::ST_SHIFT: begin
                // read entry j+2 while writing entry j+1, read last cycle, down to j
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = chk_reg;
                    wr_data = rd_data;
                end
                if (shift_more) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(shift_reg);
                    chk_next   = AW'(shift_reg - 1'b1);
                    pend_next  = 1'b1;
                    shift_next = shift_reg + 1'b1;
                end else if (!pend_reg) begin
                    count_next = count_reg - 1'b1;
                    if (item_reg.op == dvrt_pkg::OP_DELETE) begin
                        emit_en           = 1'b1;
                        emit_data.action  = dvrt_pkg::ACT_DELETE;
                        emit_data.node_id = key_reg;
                    end
                end
            end
            dvrt_pkg::ST_TICK: begin
                if (!tick_end) begin
                    tick_next = tick_reg + 1'b1;
                    if (nb_node_reg[tidx] != 8'd0) begin
                        if (age_inc > timeout_reg) begin
                            key_next           = nb_node_reg[tidx];
                            emit_en            = 1'b1;
                            emit_data.action   = dvrt_pkg::ACT_DELETE;
                            emit_data.node_id  = nb_node_reg[tidx];
                            nb_node_next[tidx] = 8'd0;
                            nb_age_next[tidx]  = 8'd0;
                        end else begin
                            nb_age_next[tidx] = age_inc;
                        end
                    end
                end
            end
            dvrt_pkg::ST_READ: begin
                emit_en   = 1'b1;
                emit_data = '{action: dvrt_pkg::ACT_ENTRY, node_id: rd_data.dest,
                              next_hop: rd_data.next_hop, hops: rd_data.hop_count,
                              valid: 1'b1};
            end
            dvrt_pkg::ST_LAST: begin
                if (item_reg.op == dvrt_pkg::OP_NEW_HERE || changed_reg) begin
                    emit_en          = 1'b1;
                    emit_data.action = dvrt_pkg::ACT_BROADCAST;
                end
                if (item_reg.op == dvrt_pkg::OP_ENTRY) changed_next = 1'b0;
            end
            dvrt_pkg::ST_OUT: begin
                if (m_valid && m_ready) out_idx_next = out_idx_reg + 2'd1;
            end
            default: ;
        endcase
    end

    assign res_n_next = (state_reg == dvrt_pkg::ST_IDLE) ? 3'd0 :
                        (emit_en && res_n_reg < dvrt_pkg::RESULT_SLOTS) ? res_n_reg + 3'd1 :
                        res_n_reg;

    always_comb begin
        m_data              = '0;
        m_data.action       = res_reg[out_idx_reg].action;
        m_data.node_id_out  = res_reg[out_idx_reg].node_id;
        m_data.next_hop_out = res_reg[out_idx_reg].next_hop;
        m_data.hops_out     = res_reg[out_idx_reg].hops;
        m_data.entry_valid  = res_reg[out_idx_reg].valid;
        m_data.table_count  = 5'(count_reg);
        m_data.last_result  = out_last;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dvrt_pkg::ST_IDLE;
            count_reg   <= '0;
            changed_reg <= 1'b0;
            res_n_reg   <= '0;
            out_idx_reg <= '0;
            pend_reg    <= 1'b0;
            for (int i = 0; i < PORT_COUNT; i++) begin
                nb_node_reg[i] <= 8'd0;
                nb_age_reg[i]  <= 8'd0;
            end
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            changed_reg <= changed_next;
            res_n_reg   <= res_n_next;
            out_idx_reg <= out_idx_next;
            pend_reg    <= pend_next;
            nb_node_reg <= nb_node_next;
            nb_age_reg  <= nb_age_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        key_reg   <= key_next;
        issue_reg <= issue_next;
        chk_reg   <= chk_next;
        found_reg <= found_next;
        shift_reg <= shift_next;
        tick_reg  <= tick_next;
        if (emit_en && res_n_reg < dvrt_pkg::RESULT_SLOTS) begin
            res_reg[res_n_reg[1:0]] <= emit_data;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_id_reg   <= dvrt_pkg::MY_ID_RESET;
            timeout_reg <= dvrt_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == dvrt_pkg::REG_MY_ID) my_id_reg <= pwdata[7:0];
            else                                 timeout_reg <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {24'd0, (paddr[2] == dvrt_pkg::REG_TIMEOUT) ? timeout_reg : my_id_reg};

endmodule

// File: dv/distance_vector_route_table_core_tb.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_core_tb
// Drives message events and ticks into the route table core, predicts every
// action item with a behavioral model of the table and neighbor ages, and
// compares results field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_vector_route_table_core_tb;

    localparam int ROUTES = 16;
    localparam int PORTS  = 4;
    localparam int RANDOM_ITEMS = 500;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    dvrt_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    dvrt_pkg::out_item_t m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    distance_vector_route_table_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [7:0] rt_dest [ROUTES];
    logic [7:0] rt_nh   [ROUTES];
    logic [7:0] rt_hc   [ROUTES];
    int         rt_count;
    logic [7:0] nb_node [PORTS];
    logic [7:0] nb_age  [PORTS];
    logic       changed;
    logic [7:0] node_id_cfg;
    logic [7:0] timeout_cfg;

    dvrt_pkg::out_item_t expected_actions[$];
    dvrt_pkg::out_item_t step_buf[$];
    int         errors;
    int         results_seen;
    int         items_sent;
    bit         idle_on;

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int find_route(input logic [7:0] dest);
        for (int i = 0; i < rt_count; i++)
            if (rt_dest[i] == dest) return i;
        return rt_count;
    endfunction

    function automatic void push_action(input logic [2:0] act, input logic [7:0] node,
                                        input logic [7:0] nh, input logic [7:0] hc,
                                        input logic vld);
        dvrt_pkg::out_item_t r;
        if (step_buf.size() >= 4) return;
        r = '0;
        r.action = act; r.node_id_out = node; r.next_hop_out = nh;
        r.hops_out = hc; r.entry_valid = vld;
        step_buf.push_back(r);
    endfunction

    function automatic bit learn_route(input logic [7:0] id);
        int i;
        i = find_route(id);
        if (i >= rt_count) begin
            if (rt_count >= ROUTES) return 0;
            rt_count++;
            rt_dest[i] = id;
        end
        rt_nh[i] = id;
        rt_hc[i] = 8'd1;
        return 1;
    endfunction

    function automatic bit drop_route(input logic [7:0] node, input logic [7:0] via);
        int i;
        i = find_route(node);
        if (i >= rt_count || rt_nh[i] != via) return 0;
        for (int j = i; j + 1 < rt_count; j++) begin
            rt_dest[j] = rt_dest[j+1];
            rt_nh[j]   = rt_nh[j+1];
            rt_hc[j]   = rt_hc[j+1];
        end
        rt_count--;
        return 1;
    endfunction

    function automatic void note_neighbor(input int p, input logic [7:0] sender,
                                          input bit do_learn);
        if (nb_node[p] != sender) begin
            if (do_learn && !learn_route(sender))
                push_action(dvrt_pkg::ACT_FULL, sender, 0, 0, 0);
            nb_node[p] = sender;
        end
        nb_age[p] = 0;
    endfunction

    function automatic void route_table_step(input dvrt_pkg::in_item_t it);
        logic [7:0] cost;
        logic [7:0] nb;
        int i;
        step_buf.delete();
        case (it.op)
            dvrt_pkg::OP_PING: note_neighbor(it.port, it.sender_id, 1);
            dvrt_pkg::OP_NEW_HERE: begin
                if (!learn_route(it.sender_id))
                    push_action(dvrt_pkg::ACT_FULL, it.sender_id, 0, 0, 0);
                note_neighbor(it.port, it.sender_id, 0);
                push_action(dvrt_pkg::ACT_BROADCAST, 0, 0, 0, 0);
            end
            dvrt_pkg::OP_ENTRY: begin
                cost = (it.hops == dvrt_pkg::HOPS_MAX) ? dvrt_pkg::HOPS_MAX
                                                       : it.hops + 8'd1;
                i = find_route(it.node_id);
                if (i < rt_count) begin
                    if (rt_hc[i] > cost) begin
                        rt_nh[i] = it.sender_id;
                        rt_hc[i] = cost;
                        changed = 1;
                    end
                end else if (it.node_id != node_id_cfg) begin
                    if (rt_count < ROUTES) begin
                        rt_dest[i] = it.node_id;
                        rt_nh[i] = it.sender_id;
                        rt_hc[i] = cost;
                        rt_count++;
                        changed = 1;
                    end else begin
                        push_action(dvrt_pkg::ACT_FULL, it.node_id, 0, 0, 0);
                    end
                end
                if (it.last_entry) begin
                    if (changed) push_action(dvrt_pkg::ACT_BROADCAST, 0, 0, 0, 0);
                    changed = 0;
                end
            end
            dvrt_pkg::OP_DELETE: begin
                if (it.node_id == node_id_cfg)
                    push_action(dvrt_pkg::ACT_ANNOUNCE, 0, 0, 0, 0);
                else if (drop_route(it.node_id, it.sender_id))
                    push_action(dvrt_pkg::ACT_DELETE, it.node_id, 0, 0, 0);
                else
                    push_action(dvrt_pkg::ACT_BROADCAST, 0, 0, 0, 0);
            end
            dvrt_pkg::OP_TICK: begin
                for (int p = 0; p < PORTS; p++) begin
                    nb = nb_node[p];
                    if (nb != 0) begin
                        if (nb_age[p] < 8'd255) nb_age[p]++;
                        if (nb_age[p] > timeout_cfg) begin
                            void'(drop_route(nb, nb));
                            push_action(dvrt_pkg::ACT_DELETE, nb, 0, 0, 0);
                            nb_node[p] = 0;
                            nb_age[p] = 0;
                        end
                    end
                end
            end
            dvrt_pkg::OP_READ: begin
                if (it.entry_index < rt_count)
                    push_action(dvrt_pkg::ACT_ENTRY, rt_dest[it.entry_index],
                                rt_nh[it.entry_index], rt_hc[it.entry_index], 1);
                else
                    push_action(dvrt_pkg::ACT_ENTRY, 0, 0, 0, 0);
            end
            default: ;
        endcase
        for (int k = 0; k < step_buf.size(); k++) begin
            step_buf[k].table_count = rt_count[4:0];
            step_buf[k].last_result = (k == step_buf.size() - 1);
            expected_actions.push_back(step_buf[k]);
        end
    endfunction

    // ---------------------------------------------------------------- clock
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("distance_vector_route_table_core_tb: FAIL");
        $finish;
    end

    // result side: random stalls and checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_actions.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_data));
                end else begin
                    dvrt_pkg::out_item_t e;
                    e = expected_actions.pop_front();
                    if (m_data.action != e.action)
                        report_mismatch($sformatf("action %0d exp %0d", m_data.action,
                                                  e.action));
                    if (m_data.node_id_out != e.node_id_out)
                        report_mismatch($sformatf("node_id_out %0d exp %0d",
                                                  m_data.node_id_out, e.node_id_out));
                    if (m_data.next_hop_out != e.next_hop_out)
                        report_mismatch($sformatf("next_hop_out %0d exp %0d",
                                                  m_data.next_hop_out, e.next_hop_out));
                    if (m_data.hops_out != e.hops_out)
                        report_mismatch($sformatf("hops_out %0d exp %0d",
                                                  m_data.hops_out, e.hops_out));
                    if (m_data.entry_valid != e.entry_valid)
                        report_mismatch($sformatf("entry_valid %0d exp %0d",
                                                  m_data.entry_valid, e.entry_valid));
                    if (m_data.table_count != e.table_count)
                        report_mismatch($sformatf("table_count %0d exp %0d",
                                                  m_data.table_count, e.table_count));
                    if (m_data.last_result != e.last_result)
                        report_mismatch($sformatf("last_result %0d exp %0d",
                                                  m_data.last_result, e.last_result));
                end
            end
            m_ready <= idle_on ? ($urandom_range(99) >= 8) : 1'b1;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [7:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
        pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'(dvrt_pkg::REG_MY_ID) * 3'd4) node_id_cfg = value;
        else timeout_cfg = value;
    endtask

    // waits for all results, then for trailing work of result-less items
    task automatic drain;
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_actions.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (60) @(posedge aclk);
    endtask

    // valid stays up between items unless an idle cycle is drawn
    task automatic send_item(input dvrt_pkg::in_item_t it);
        if (idle_on) begin
            while ($urandom_range(99) < 8) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        route_table_step(it);
        items_sent++;
    endtask

    function automatic dvrt_pkg::in_item_t mk(input logic [2:0] op, input logic [1:0] p,
                                              input logic [7:0] snd, input logic [7:0] nd,
                                              input logic [7:0] h, input logic l,
                                              input logic [3:0] ix);
        dvrt_pkg::in_item_t it;
        it.op = op; it.port = p; it.sender_id = snd; it.node_id = nd;
        it.hops = h; it.last_entry = l; it.entry_index = ix;
        return it;
    endfunction

    // random ids come from a small pool so routes get hit again
    function automatic logic [7:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 8'($urandom_range(2, 24));
        else if (r < 85) return 8'd0;
        else return 8'($urandom);
    endfunction

    typedef struct {
        dvrt_pkg::in_item_t  item;
        bit                  has_exp;
        dvrt_pkg::out_item_t exp;
    } dir_row_t;

    initial begin
        dir_row_t            rows[$];
        dir_row_t            row;
        dvrt_pkg::in_item_t  it;
        dvrt_pkg::out_item_t e;
        int                  r;
        int                  phase;
        int                  id_a;

        s_valid = 0; s_data = '0; psel = 0; penable = 0; pwrite = 0;
        paddr = '0; pwdata = '0; aresetn = 0;
        errors = 0; results_seen = 0; items_sent = 0; idle_on = 1;
        for (int i = 0; i < ROUTES; i++) begin
            rt_dest[i] = 0; rt_nh[i] = 0; rt_hc[i] = 0;
        end
        for (int p = 0; p < PORTS; p++) begin
            nb_node[p] = 0; nb_age[p] = 0;
        end
        rt_count = 0; changed = 0;
        node_id_cfg = dvrt_pkg::MY_ID_RESET; timeout_cfg = dvrt_pkg::TIMEOUT_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; typed expectations only where obvious
        e = '0; e.action = dvrt_pkg::ACT_ENTRY; e.last_result = 1;
        rows.push_back('{mk(dvrt_pkg::OP_READ, 0, 0, 0, 0, 0, 4'd15), 1, e});
        e = '0; e.action = dvrt_pkg::ACT_BROADCAST; e.last_result = 1;
        rows.push_back('{mk(dvrt_pkg::OP_DELETE, 0, 8'd9, 8'd200, 0, 0, 0), 1, e});
        e = '0; e.action = dvrt_pkg::ACT_ANNOUNCE; e.last_result = 1;
        rows.push_back('{mk(dvrt_pkg::OP_DELETE, 0, 8'd9, dvrt_pkg::MY_ID_RESET, 0, 0, 0),
                         1, e});
        rows.push_back('{mk(dvrt_pkg::OP_PING, 0, 8'd2, 0, 0, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_PING, 2'd3, 8'd255, 0, 0, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_NEW_HERE, 2'd1, 8'd3, 0, 0, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_ENTRY, 0, 8'd2, 8'd40, 8'd255, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_ENTRY, 0, 8'd2, 8'd41, 8'd0, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_ENTRY, 0, 8'd3, 8'd40, 8'd254, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_ENTRY, 0, 8'd3, dvrt_pkg::MY_ID_RESET, 8'd3, 1, 0),
                         0, e});
        rows.push_back('{mk(dvrt_pkg::OP_ENTRY, 0, 8'd3, 8'd41, 8'd7, 1, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_READ, 0, 0, 0, 0, 0, 4'd0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_READ, 0, 0, 0, 0, 0, 4'd3), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_DELETE, 0, 8'd2, 8'd41, 0, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_PING, 2'd3, 8'd0, 0, 0, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_NEW_HERE, 2'd2, 8'd0, 0, 0, 0, 0), 0, e});
        rows.push_back('{mk(3'd6, 2'd1, 8'hAA, 8'h55, 8'hFF, 1, 4'hF), 0, e});
        rows.push_back('{mk(3'd7, 2'd2, 8'h55, 8'hAA, 8'h00, 0, 4'h0), 0, e});
        for (int t = 0; t < 12; t++)
            rows.push_back('{mk(dvrt_pkg::OP_TICK, 0, 0, 0, 0, 0, 0), 0, e});
        // fill the table to overflow
        for (int k = 0; k < 18; k++)
            rows.push_back('{mk(dvrt_pkg::OP_ENTRY, 2'd1, 8'd7, 8'(100 + k), 8'd5, k == 17,
                                0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_NEW_HERE, 2'd0, 8'd99, 0, 0, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_PING, 2'd1, 8'd98, 0, 0, 0, 0), 0, e});
        rows.push_back('{mk(dvrt_pkg::OP_READ, 0, 0, 0, 0, 0, 4'd15), 0, e});

        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.item);
            if (row.has_exp) begin
                // typed row must match the predictor's view
                if (step_buf.size() != 1 || step_buf[0] != row.exp)
                    report_mismatch($sformatf("directed row %0d expectation", i));
            end
        end
        drain();

        // random phases with different register settings, extremes included
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin reg_write(3'(dvrt_pkg::REG_MY_ID) * 3'd4, 8'd255);
                          reg_write(3'(dvrt_pkg::REG_TIMEOUT) * 3'd4, 8'd1); end
                1: begin reg_write(3'(dvrt_pkg::REG_MY_ID) * 3'd4, 8'd5);
                          reg_write(3'(dvrt_pkg::REG_TIMEOUT) * 3'd4, 8'd254); end
                2: begin reg_write(3'(dvrt_pkg::REG_MY_ID) * 3'd4, 8'd1);
                          reg_write(3'(dvrt_pkg::REG_TIMEOUT) * 3'd4, 8'd3); end
                default: begin
                    reg_write(3'(dvrt_pkg::REG_MY_ID) * 3'd4, 8'($urandom_range(1, 255)));
                    reg_write(3'(dvrt_pkg::REG_TIMEOUT) * 3'd4, 8'($urandom_range(1, 20)));
                end
            endcase
            idle_on = (phase != 1);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                r = $urandom_range(99);
                it = dvrt_pkg::in_item_t'({$urandom, $urandom});
                it.port = 2'($urandom);
                it.sender_id = pick_id();
                it.node_id = ($urandom_range(9) == 0) ? node_id_cfg : pick_id();
                it.hops = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
                it.last_entry = ($urandom_range(3) == 0);
                it.entry_index = 4'($urandom);
                if (r < 10) it.op = dvrt_pkg::OP_PING;
                else if (r < 18) it.op = dvrt_pkg::OP_NEW_HERE;
                else if (r < 50) it.op = dvrt_pkg::OP_ENTRY;
                else if (r < 65) begin
                    it.op = dvrt_pkg::OP_DELETE;
                    // often name a route that exists via its real next hop
                    if (rt_count > 0 && $urandom_range(1)) begin
                        id_a = $urandom_range(rt_count - 1);
                        it.node_id = rt_dest[id_a];
                        it.sender_id = rt_nh[id_a];
                    end
                end
                else if (r < 83) it.op = dvrt_pkg::OP_TICK;
                else if (r < 97) it.op = dvrt_pkg::OP_READ;
                else it.op = 3'($urandom_range(6, 7));
                send_item(it);
            end
            drain();
        end
        drain();

        $display("covered %0d items, %0d results checked, 5 register settings",
                 items_sent, results_seen);
        if (errors == 0 && expected_actions.size() == 0) begin
            $display("distance_vector_route_table_core_tb: PASS");
        end else begin
            $display("distance_vector_route_table_core_tb: FAIL");
        end
        $finish;
    end

endmodule
